// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the box frustum clip classifier.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfc assertion failed");

`endif

// ----- rtl/bfc_pkg.sv -----
// Package of the box frustum clip classifier: sizes, register reset values
// and the structs passed between the front, the queue and the back part.
// No dependencies.
package bfc_pkg;

    localparam int CORNERS   = 8;
    localparam int CNT_W     = (CORNERS > 1) ? $clog2(CORNERS) : 1;
    localparam int NUM_REGS  = 8;
    localparam int REG_SEL_W = $clog2(NUM_REGS);
    localparam int REG_IDX_W = 4;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    typedef logic [NUM_REGS-1:0][63:0] t_matrix;

    // The reset matrix is the identity.
    localparam t_matrix MATRIX_RESET = {
        64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
        64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
    };

    typedef struct packed {
        logic depth;
        logic side;
    } t_flags;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic pop;
        logic last;
    } t_back_stat;

endpackage

// ----- rtl/bfc_front.sv -----
// Front part: transforms one corner per cycle, while o_ready is high, by
// the matrix and classifies it. Three register stages: products, pair sums,
// row sums; flags go to the queue. Depends on bfc_pkg.
module bfc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bfc_pkg::t_matrix     i_matrix,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [31:0]   i_corner_x,
    input  logic signed [31:0]   i_corner_y,
    input  logic signed [31:0]   i_corner_z,
    input  logic                 i_q_full,
    output logic                 o_push,
    output bfc_pkg::t_flags      o_flags
);
    import bfc_pkg::*;

    logic [2:0]         r_v;
    logic               w_adv;
    logic signed [65:0] w_sum [4];
    logic signed [66:0] w_zw;
    logic signed [66:0] w_xw;
    logic signed [66:0] w_wx;
    logic signed [66:0] w_yw;
    logic signed [66:0] w_wy;

    assign w_adv   = !r_v[2] || !i_q_full;
    assign o_ready = w_adv;
    assign o_push  = r_v[2] && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    for (genvar r = 0; r < 4; r++) begin : g_row
        logic signed [31:0] w_c0, w_c1, w_c2, w_c3;
        logic signed [63:0] r_p0, r_p1, r_p2, r_t;
        logic signed [64:0] r_a, r_b;
        logic signed [65:0] r_s;

        assign w_c0 = i_matrix[2*r][31:0];
        assign w_c1 = i_matrix[2*r][63:32];
        assign w_c2 = i_matrix[2*r+1][31:0];
        assign w_c3 = i_matrix[2*r+1][63:32];

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_p0 <= w_c0 * i_corner_x;
                r_p1 <= w_c1 * i_corner_y;
                r_p2 <= w_c2 * i_corner_z;
                r_t  <= {{16{w_c3[31]}}, w_c3, 16'h0000};
                r_a  <= {r_p0[63], r_p0} + {r_p1[63], r_p1};
                r_b  <= {r_p2[63], r_p2} + {r_t[63], r_t};
                r_s  <= {r_a[64], r_a} + {r_b[64], r_b};
            end
        end

        assign w_sum[r] = r_s;
    end

    assign w_zw = {w_sum[2][65], w_sum[2]} + {w_sum[3][65], w_sum[3]};
    assign w_xw = {w_sum[0][65], w_sum[0]} + {w_sum[3][65], w_sum[3]};
    assign w_wx = {w_sum[3][65], w_sum[3]} - {w_sum[0][65], w_sum[0]};
    assign w_yw = {w_sum[1][65], w_sum[1]} + {w_sum[3][65], w_sum[3]};
    assign w_wy = {w_sum[3][65], w_sum[3]} - {w_sum[1][65], w_sum[1]};

    always_comb begin
        o_flags.depth = w_zw[66] || (!w_sum[2][65] && (w_sum[2] != '0));
        o_flags.side  = w_xw[66] || w_wx[66] || w_yw[66] || w_wy[66];
    end

endmodule

// ----- rtl/bfc_queue.sv -----
// Short queue of per-corner flags between the front and the back part.
// Depends on bfc_pkg.
module bfc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bfc_pkg::t_flags      i_flags,
    input  logic                 i_pop,
    output bfc_pkg::t_flags      o_flags,
    output bfc_pkg::t_q_stat     o_stat
);
    import bfc_pkg::*;

    t_flags             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_flags      = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ----- rtl/bfc_back.sv -----
// Back part: ORs the corner flags over a box and holds the result word.
// Depends on bfc_pkg.
module bfc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bfc_pkg::t_flags      i_flags,
    input  logic                 i_q_empty,
    output bfc_pkg::t_back_stat  o_stat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_depth_clip,
    output logic                 o_side_clip
);
    import bfc_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    t_flags           r_seen;
    logic             r_ov;
    t_flags           r_out;
    logic             w_last;
    logic             w_pop;

    assign w_last = (r_cnt == CNT_W'(CORNERS - 1));
    assign w_pop  = !i_q_empty && (!w_last || !r_ov || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_seen <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (w_pop) begin
                if (w_last) begin
                    r_cnt  <= '0;
                    r_seen <= '0;
                end else begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_seen <= r_seen | i_flags;
                end
            end
            if (w_pop && w_last) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_last) begin
            r_out <= r_seen | i_flags;
        end
    end

    assign o_stat.pop   = w_pop;
    assign o_stat.last  = w_last;
    assign o_valid      = r_ov;
    assign o_depth_clip = r_out.depth;
    assign o_side_clip  = r_out.side;

endmodule

// ----- rtl/box_frustum_clip_classifier.sv -----
// Top level of the box frustum clip classifier: matrix registers and the
// front, queue and back parts. Depends on bfc_pkg, bfc_front, bfc_queue,
// bfc_back and assert_macros.svh.
//
// The block takes box corners on the input channel (i_valid, o_ready and
// signed Q16.16 corner coordinates) and gives one result word per box of
// eight corners on the output channel (o_valid, i_ready, o_depth_clip,
// o_side_clip). Each corner is transformed by the 4x4 matrix held in eight
// 64-bit registers that are written over the configuration channel; writes
// to an index beyond the last register are ignored. One corner is taken
// every cycle in which o_ready is high. The result of a box passes
// through the product, pair sum and row sum registers, then the queue
// and the output register. Reset loads the identity matrix and empties
// the pipeline, the queue and the corner count. When the receiver stalls,
// the result waits in the output register while the back part gathers
// the next box from the queue; a corner facing a full queue drops o_ready.
`include "assert_macros.svh"

module box_frustum_clip_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [31:0]            i_corner_x,
    input  logic signed [31:0]            i_corner_y,
    input  logic signed [31:0]            i_corner_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_depth_clip,
    output logic                          o_side_clip,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bfc_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);
    import bfc_pkg::*;

    t_matrix    r_matrix;
    logic       w_push;
    t_flags     w_front_flags;
    t_flags     w_q_flags;
    t_q_stat    w_q_stat;
    t_back_stat w_back_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix <= MATRIX_RESET;
        end else if (i_cfg_valid && (i_cfg_index < REG_IDX_W'(NUM_REGS))) begin
            r_matrix[i_cfg_index[REG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    bfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_matrix   (r_matrix),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_corner_x (i_corner_x),
        .i_corner_y (i_corner_y),
        .i_corner_z (i_corner_z),
        .i_q_full   (w_q_stat.full),
        .o_push     (w_push),
        .o_flags    (w_front_flags)
    );

    bfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_flags (w_front_flags),
        .i_pop   (w_back_stat.pop),
        .o_flags (w_q_flags),
        .o_stat  (w_q_stat)
    );

    bfc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_flags      (w_q_flags),
        .i_q_empty    (w_q_stat.empty),
        .o_stat       (w_back_stat),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_depth_clip (o_depth_clip),
        .o_side_clip  (o_side_clip)
    );

    `BFC_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, w_back_stat.pop, !w_q_stat.empty)
    `BFC_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_valid && !i_ready && w_back_stat.pop, !w_back_stat.last)
    `BFC_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, w_back_stat.pop && w_back_stat.last, o_valid)
    `BFC_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, w_q_stat.full && !w_back_stat.pop, !w_push)

endmodule
